[rtl/core/pcm_pkg.sv]
// Package for the correlation magnitude block: sequencer states,
// product-step codes and fixed datapath widths.
// No dependencies.
`timescale 1ns / 1ps

package pcm_pkg;

   // Operand limb width of the shared multiplier
   localparam int LIMB_W = 32;
   // Wide operand width, two limbs
   localparam int WIDE_W = 64;
   // Accumulator width, 128-bit products plus sign and guard
   localparam int ACC_W  = 130;
   // Quotient bits of the ratio stage, ratio is at most 2^30
   localparam int QUO_W  = 31;
   // Root width, root is at most 32768
   localparam int ROOT_W = 16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACC,
      ST_PROD_MUL,
      ST_PROD_ADD,
      ST_DIV,
      ST_SQ_MUL,
      ST_SQ_CMP,
      ST_DONE
   } state_type;

   // End-of-frame product steps, in execution order
   typedef enum logic [2:0] {
      OP_N_CROSS,
      OP_FAR_NEAR,
      OP_N_FAR_SQ,
      OP_FAR_FAR,
      OP_N_NEAR_SQ,
      OP_NEAR_NEAR,
      OP_VAR_VAR,
      OP_COV_COV
   } op_type;

endpackage

[rtl/core/pcm_mul.sv]
// Shared 32x32 unsigned multiplier with a registered product.
// Uses pcm_pkg for the limb width.
`timescale 1ns / 1ps

module pcm_mul
   import pcm_pkg::*;
(
   input  logic                clock,
   input  logic [LIMB_W-1:0]   mul_a,
   input  logic [LIMB_W-1:0]   mul_b,
   output logic [2*LIMB_W-1:0] mul_p
);

   logic [2*LIMB_W-1:0] prod_ff;
   logic [2*LIMB_W-1:0] prod_in;

   // Form the product
   assign prod_in = (2*LIMB_W)'(mul_a) * (2*LIMB_W)'(mul_b);

   // Register it
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign mul_p = prod_ff;

endmodule

[rtl/core/pearson_correlation_magnitude.sv]
// Top level of the correlation magnitude block: sequencer and datapath
// around one shared multiplier. Depends on pcm_pkg and pcm_mul.
`timescale 1ns / 1ps

// Magnitude of the Pearson correlation coefficient over a frame of paired
// far/near samples. Each request carries one sample pair; after accepting
// a pair the block runs the multiplier for the two squares and the cross
// product and accepts no new pair until these are accumulated. The pair
// marked by req_tlast closes the frame: the block then forms the n-scaled
// covariance terms with 32x32 partial products (8 products of 4 partial
// products each), divides by a 31-step restoring divider and takes the
// square root with 16 multiply-and-compare steps; when a variance is zero
// it skips the remaining products, the division and the root.
// The result is |r| in unsigned Q1.15 rounded toward zero, 32768 meaning
// 1.0; zero_variance reports a constant signal (result 0), and
// length_overflow reports pairs dropped beyond MAX_FRAME_LEN. A result
// waits in an output register; the sums clear when it is loaded.
module pearson_correlation_magnitude
   import pcm_pkg::*;
#(
   parameter int MAX_FRAME_LEN = 1024
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // far_sample[15:0], near_sample[31:16]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // coef_magnitude[15:0], zero_variance[16],
                                    // length_overflow[17], zero fill[23:18]
);

   localparam int CW = $clog2(MAX_FRAME_LEN + 1);
   localparam int SW = CW + 16;
   localparam int QW = CW + 30;
   localparam int XW = CW + 31;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;

   logic [CW-1:0]           count_ff, count_in;
   logic signed [SW-1:0]    sum_far_ff, sum_far_in;
   logic signed [SW-1:0]    sum_near_ff, sum_near_in;
   logic [QW-1:0]           sq_far_ff, sq_far_in;
   logic [QW-1:0]           sq_near_ff, sq_near_in;
   logic signed [XW-1:0]    cross_ff, cross_in;
   logic                    drop_ff, drop_in;

   logic signed [15:0]      x_ff, x_in, y_ff, y_in;
   logic                    last_ff, last_in;
   logic [1:0]              step_ff, step_in;
   logic [1:0]              pp_ff, pp_in;

   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [WIDE_W-1:0]       sxy_ff, sxy_in, sxx_ff, sxx_in, syy_ff, syy_in;
   logic [2*WIDE_W-1:0]     pbig_ff, pbig_in, rem_ff, rem_in;
   logic                    r0lsb_ff, r0lsb_in;
   logic [4:0]              dcnt_ff, dcnt_in;
   logic [QUO_W-1:0]        quo_ff, quo_in;
   logic [ROOT_W-1:0]       root_ff, root_in;
   logic [3:0]              bit_ff, bit_in;
   logic                    zv_ff, zv_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [15:0]             coef_ff, coef_in;
   logic                    rzv_ff, rzv_in, rovf_ff, rovf_in;

   logic [LIMB_W-1:0]       mul_a, mul_b;
   logic [2*LIMB_W-1:0]     mul_p;

   logic [15:0]             x_mag, y_mag;
   logic [SW-1:0]           sf_mag, sn_mag;
   logic [XW-1:0]           sc_mag;
   logic [WIDE_W-1:0]       op_a, op_b;
   logic                    op_sub;
   logic [2*WIDE_W-1:0]     term;
   logic signed [ACC_W-1:0] acc_sum, acc_abs;
   logic [2*WIDE_W:0]       rem_sh, rem_diff;
   logic [ROOT_W-1:0]       trial;
   logic                    req_fire;

   pcm_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   assign req_fire = req_tvalid && req_tready;

   // Magnitudes of the latched samples and of the sums
   assign x_mag  = x_ff[15] ? 16'(-x_ff) : 16'(x_ff);
   assign y_mag  = y_ff[15] ? 16'(-y_ff) : 16'(y_ff);
   assign sf_mag = sum_far_ff[SW-1]  ? SW'(-sum_far_ff)  : SW'(sum_far_ff);
   assign sn_mag = sum_near_ff[SW-1] ? SW'(-sum_near_ff) : SW'(sum_near_ff);
   assign sc_mag = cross_ff[XW-1]    ? XW'(-cross_ff)    : XW'(cross_ff);

   // Select the wide operands and the sign of each end-of-frame product
   always_comb begin
      op_a   = '0;
      op_b   = '0;
      op_sub = 1'b0;
      unique case (op_ff)
         OP_N_CROSS: begin
            op_a   = WIDE_W'(count_ff);
            op_b   = WIDE_W'(sc_mag);
            op_sub = cross_ff[XW-1];
         end
         OP_FAR_NEAR: begin
            op_a   = WIDE_W'(sf_mag);
            op_b   = WIDE_W'(sn_mag);
            op_sub = ~(sum_far_ff[SW-1] ^ sum_near_ff[SW-1]);
         end
         OP_N_FAR_SQ: begin
            op_a = WIDE_W'(count_ff);
            op_b = WIDE_W'(sq_far_ff);
         end
         OP_FAR_FAR: begin
            op_a   = WIDE_W'(sf_mag);
            op_b   = WIDE_W'(sf_mag);
            op_sub = 1'b1;
         end
         OP_N_NEAR_SQ: begin
            op_a = WIDE_W'(count_ff);
            op_b = WIDE_W'(sq_near_ff);
         end
         OP_NEAR_NEAR: begin
            op_a   = WIDE_W'(sn_mag);
            op_b   = WIDE_W'(sn_mag);
            op_sub = 1'b1;
         end
         OP_VAR_VAR: begin
            op_a = sxx_ff;
            op_b = syy_ff;
         end
         OP_COV_COV: begin
            op_a = sxy_ff;
            op_b = sxy_ff;
         end
         default: begin
            op_a = '0;
         end
      endcase
   end

   // Place the partial product at its limb offset and accumulate it
   always_comb begin
      unique case (pp_ff)
         2'd0:    term = (2*WIDE_W)'(mul_p);
         2'd3:    term = (2*WIDE_W)'(mul_p) << (2*LIMB_W);
         default: term = (2*WIDE_W)'(mul_p) << LIMB_W;
      endcase
   end

   assign acc_sum = op_sub ? acc_ff - ACC_W'(term) : acc_ff + ACC_W'(term);
   assign acc_abs = acc_sum[ACC_W-1] ? -acc_sum : acc_sum;

   // Restoring division step and square root trial
   assign rem_sh   = {rem_ff, (dcnt_ff == 5'd0) ? r0lsb_ff : 1'b0};
   assign rem_diff = rem_sh - {1'b0, pbig_ff};
   assign trial    = root_ff | (ROOT_W'(1) << bit_ff);

   // Sequencer: next state, datapath updates and multiplier operands
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      count_in     = count_ff;
      sum_far_in   = sum_far_ff;
      sum_near_in  = sum_near_ff;
      sq_far_in    = sq_far_ff;
      sq_near_in   = sq_near_ff;
      cross_in     = cross_ff;
      drop_in      = drop_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      last_in      = last_ff;
      step_in      = step_ff;
      pp_in        = pp_ff;
      acc_in       = acc_ff;
      sxy_in       = sxy_ff;
      sxx_in       = sxx_ff;
      syy_in       = syy_ff;
      pbig_in      = pbig_ff;
      rem_in       = rem_ff;
      r0lsb_in     = r0lsb_ff;
      dcnt_in      = dcnt_ff;
      quo_in       = quo_ff;
      root_in      = root_ff;
      bit_in       = bit_ff;
      zv_in        = zv_ff;
      rsp_valid_in = rsp_valid_ff;
      coef_in      = coef_ff;
      rzv_in       = rzv_ff;
      rovf_in      = rovf_ff;
      mul_a        = '0;
      mul_b        = '0;
      req_tready   = 1'b0;

      // Release the result once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_fire) begin
               x_in    = req_tdata[15:0];
               y_in    = req_tdata[31:16];
               last_in = req_tlast;
               step_in = 2'd0;
               op_in   = OP_N_CROSS;
               pp_in   = 2'd0;
               acc_in  = '0;
               if (count_ff < CW'(MAX_FRAME_LEN)) begin
                  state_in = ST_ACC;
               end else begin
                  // Drop the pair; a last flag still closes the frame
                  drop_in  = 1'b1;
                  state_in = req_tlast ? ST_PROD_MUL : ST_IDLE;
               end
            end
         end

         ST_ACC: begin
            step_in = step_ff + 2'd1;
            unique case (step_ff)
               2'd0: begin
                  mul_a = LIMB_W'(x_mag);
                  mul_b = LIMB_W'(x_mag);
               end
               2'd1: begin
                  mul_a     = LIMB_W'(y_mag);
                  mul_b     = LIMB_W'(y_mag);
                  sq_far_in = sq_far_ff + QW'(mul_p[31:0]);
               end
               2'd2: begin
                  mul_a      = LIMB_W'(x_mag);
                  mul_b      = LIMB_W'(y_mag);
                  sq_near_in = sq_near_ff + QW'(mul_p[31:0]);
               end
               default: begin
                  cross_in    = (x_ff[15] ^ y_ff[15]) ?
                                cross_ff - XW'(mul_p[31:0]) :
                                cross_ff + XW'(mul_p[31:0]);
                  sum_far_in  = sum_far_ff + SW'(x_ff);
                  sum_near_in = sum_near_ff + SW'(y_ff);
                  count_in    = count_ff + CW'(1);
                  state_in    = last_ff ? ST_PROD_MUL : ST_IDLE;
               end
            endcase
         end

         ST_PROD_MUL: begin
            mul_a    = pp_ff[1] ? op_a[63:32] : op_a[31:0];
            mul_b    = pp_ff[0] ? op_b[63:32] : op_b[31:0];
            state_in = ST_PROD_ADD;
         end

         ST_PROD_ADD: begin
            acc_in   = acc_sum;
            pp_in    = pp_ff + 2'd1;
            state_in = ST_PROD_MUL;
            if (pp_ff == 2'd3) begin
               op_in = op_type'(op_ff + 3'd1);
               priority case (op_ff)
                  OP_FAR_NEAR: begin
                     sxy_in = acc_abs[WIDE_W-1:0];
                     acc_in = '0;
                  end
                  OP_FAR_FAR: begin
                     sxx_in = acc_sum[WIDE_W-1:0];
                     acc_in = '0;
                  end
                  OP_NEAR_NEAR: begin
                     syy_in = acc_sum[WIDE_W-1:0];
                     acc_in = '0;
                     zv_in  = (sxx_ff == '0) || (acc_sum[WIDE_W-1:0] == '0);
                     if (zv_in) begin
                        state_in = ST_DONE;
                     end
                  end
                  OP_VAR_VAR: begin
                     pbig_in = acc_sum[2*WIDE_W-1:0];
                     acc_in  = '0;
                  end
                  OP_COV_COV: begin
                     rem_in   = {1'b0, acc_sum[2*WIDE_W-1:1]};
                     r0lsb_in = acc_sum[0];
                     dcnt_in  = 5'd0;
                     quo_in   = '0;
                     state_in = ST_DIV;
                  end
                  default: begin
                     acc_in = acc_sum;
                  end
               endcase
            end
         end

         ST_DIV: begin
            dcnt_in = dcnt_ff + 5'd1;
            if (!rem_diff[2*WIDE_W]) begin
               rem_in = rem_diff[2*WIDE_W-1:0];
               quo_in = {quo_ff[QUO_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[2*WIDE_W-1:0];
               quo_in = {quo_ff[QUO_W-2:0], 1'b0};
            end
            if (dcnt_ff == 5'(QUO_W - 1)) begin
               root_in  = '0;
               bit_in   = 4'(ROOT_W - 1);
               state_in = ST_SQ_MUL;
            end
         end

         ST_SQ_MUL: begin
            mul_a    = LIMB_W'(trial);
            mul_b    = LIMB_W'(trial);
            state_in = ST_SQ_CMP;
         end

         ST_SQ_CMP: begin
            if (mul_p <= (2*LIMB_W)'(quo_ff)) begin
               root_in = trial;
            end
            if (bit_ff == 4'd0) begin
               state_in = ST_DONE;
            end else begin
               bit_in   = bit_ff - 4'd1;
               state_in = ST_SQ_MUL;
            end
         end

         ST_DONE: begin
            // Load the result once the output register is free, clear sums
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               coef_in      = zv_ff ? 16'd0 : root_ff;
               rzv_in       = zv_ff;
               rovf_in      = drop_ff;
               count_in     = '0;
               sum_far_in   = '0;
               sum_near_in  = '0;
               sq_far_in    = '0;
               sq_near_in   = '0;
               cross_in     = '0;
               drop_in      = 1'b0;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and accumulator registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_N_CROSS;
         step_ff      <= 2'd0;
         pp_ff        <= 2'd0;
         dcnt_ff      <= 5'd0;
         bit_ff       <= 4'd0;
         count_ff     <= '0;
         sum_far_ff   <= '0;
         sum_near_ff  <= '0;
         sq_far_ff    <= '0;
         sq_near_ff   <= '0;
         cross_ff     <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         step_ff      <= step_in;
         pp_ff        <= pp_in;
         dcnt_ff      <= dcnt_in;
         bit_ff       <= bit_in;
         count_ff     <= count_in;
         sum_far_ff   <= sum_far_in;
         sum_near_ff  <= sum_near_in;
         sq_far_ff    <= sq_far_in;
         sq_near_ff   <= sq_near_in;
         cross_ff     <= cross_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      y_ff     <= y_in;
      last_ff  <= last_in;
      acc_ff   <= acc_in;
      sxy_ff   <= sxy_in;
      sxx_ff   <= sxx_in;
      syy_ff   <= syy_in;
      pbig_ff  <= pbig_in;
      rem_ff   <= rem_in;
      r0lsb_ff <= r0lsb_in;
      quo_ff   <= quo_in;
      root_ff  <= root_in;
      zv_ff    <= zv_in;
      coef_ff  <= coef_in;
      rzv_ff   <= rzv_in;
      rovf_ff  <= rovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rovf_ff, rzv_ff, coef_ff};

endmodule
